>>> rtl/mtfq_pkg.sv
// Shared types, codes and constants for the move-to-front rotating queue.
package mtfq_pkg;

    localparam int POP_W     = 11;
    localparam int ID_W      = 16;
    localparam int STATUS_W  = 2;
    localparam int POP_RESET = 1024;

    localparam logic CMD_SERVE    = 1'b0;
    localparam logic CMD_EXPEDITE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_SERVED    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXPEDITED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED   = 2'd2;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] person_id;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     served_id;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_SERVE_RD,
        ST_SERVE_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic fill_step;
        logic load_item;
        logic rd_head;
        logic serve_commit;
        logic srch_rd;
        logic srch_next;
        logic sh_rd;
        logic sh_wr;
        logic put_head;
        logic insert;
        logic drop;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_pos;
        logic match;
        logic k_zero;
        logic k_one;
        logic full;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/move_to_front_rotating_queue.sv
// Top level of the move-to-front rotating queue: controller, datapath and checks.
// Holds an ordered id queue in a dual-port circular slot memory (one write and one
// registered read per cycle). A serve reads the head, appends it at the tail and
// advances the head, then loads the output register. An expedite scans from the head,
// reading and then comparing each position, then moves each id ahead of the match
// back one slot by a read and a write per position, and writes the id at the head; a
// new id is placed before the head, or dropped, in the last compare step instead.
// After reset and after every population write the queue is refilled with
// 1..population at one slot per cycle; input transfers wait for that pass to end.
// Results wait in an output register, so a stalled result does not block the next
// input transfer.
module move_to_front_rotating_queue
    import mtfq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int ID_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [POP_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_st;

    mtfq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .in_valid   (in_valid),
        .in_command (in_item.command),
        .st         (dp_st),
        .cmd        (dp_cmd),
        .in_stall   (in_stall)
    );

    mtfq_dp #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (dp_cmd),
        .st        (dp_st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // one item at a time: a transfer makes the block busy
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous item in progress");

    // a population write starts the refill pass
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input open right after population write");

    // result register only loaded when empty or draining
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> dp_st.out_free)
        else $error("result overwritten while stalled");

endmodule

>>> rtl/mtfq_ctrl.sv
// Sequencing state machine for the move-to-front rotating queue.
module mtfq_ctrl
    import mtfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       in_valid,
    input  logic       in_command,
    input  dp_status_t st,
    output dp_cmd_t    cmd,
    output logic       in_stall
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (st.last_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_command == CMD_SERVE) ? ST_SERVE_RD : ST_SRCH_RD;
                end
            end
            ST_SERVE_RD:
            begin
                state_next = ST_SERVE_WR;
            end
            ST_SERVE_WR:
            begin
                state_next = ST_RESP;
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (st.match)
                begin
                    state_next = st.k_zero ? ST_PUT : ST_SH_RD;
                end
                else if (st.last_pos)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SH_RD:
            begin
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                state_next = st.k_one ? ST_PUT : ST_SH_RD;
            end
            ST_PUT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_FILL;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load_item = in_valid && !cfg_we;
            end
            ST_SERVE_RD:
            begin
                cmd.rd_head = 1'b1;
            end
            ST_SERVE_WR:
            begin
                cmd.serve_commit = 1'b1;
            end
            ST_SRCH_RD:
            begin
                cmd.srch_rd = 1'b1;
            end
            ST_SRCH_CMP:
            begin
                if (!st.match)
                begin
                    if (st.last_pos)
                    begin
                        cmd.drop   = st.full;
                        cmd.insert = !st.full;
                    end
                    else
                    begin
                        cmd.srch_next = 1'b1;
                    end
                end
            end
            ST_SH_RD:
            begin
                cmd.sh_rd = 1'b1;
            end
            ST_SH_WR:
            begin
                cmd.sh_wr = 1'b1;
            end
            ST_PUT:
            begin
                cmd.put_head = 1'b1;
            end
            ST_RESP:
            begin
                cmd.out_load = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE) || cfg_we;

endmodule

>>> rtl/mtfq_dp.sv
// Datapath: circular slot memory, head pointer, count, scan pointer and result register.
module mtfq_dp
    import mtfq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int ID_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [POP_W-1:0] cfg_wdata,
    input  in_item_t         in_item,
    input  dp_cmd_t          cmd,
    output dp_status_t       st,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item
);

    localparam int AW       = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int POP_INIT = (POP_RESET > CAPACITY) ? CAPACITY : POP_RESET;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    endfunction

    logic [SLOT_W-1:0] mem [CAPACITY];

    logic [AW-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] id_reg;
    logic [SLOT_W-1:0] rdata_reg;
    logic [ID_W-1:0]   res_served_reg;
    logic [STATUS_W-1:0] res_status_reg;
    out_item_t         out_item_reg;

    logic [31:0]       cfg_ext;
    logic [CNT_W-1:0]  cnt_cfg;
    logic [31:0]       fill_val;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [AW-1:0]     tail_addr;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     addr_dec;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign cfg_ext  = 32'(cfg_wdata);
    assign cnt_cfg  = (cfg_ext == 32'd0) ? CNT_W'(1) :
                      (cfg_ext > 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cfg_ext);
    assign fill_val = 32'(k_reg) + 32'd1;
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(cnt_reg);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(CAPACITY)) ?
                       tail_sum - (CNT_W+1)'(CAPACITY) : tail_sum;
    assign tail_addr = tail_wrap[AW-1:0];
    assign head_dec  = wrap_dec(head_reg);
    assign addr_dec  = wrap_dec(addr_reg);

    assign st.last_pos = (CNT_W'(k_reg) == cnt_reg - CNT_W'(1));
    assign st.match    = (rdata_reg == id_reg);
    assign st.k_zero   = (k_reg == '0);
    assign st.k_one    = (k_reg == AW'(1));
    assign st.full     = (cnt_reg == CNT_W'(CAPACITY));
    assign st.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = id_reg;
        if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = k_reg;
            mem_wdata = fill_val[SLOT_W-1:0];
        end
        else if (cmd.serve_commit)
        begin
            mem_we    = !st.full;
            mem_waddr = tail_addr;
            mem_wdata = rdata_reg;
        end
        else if (cmd.sh_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.put_head)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = id_reg;
        end
        else if (cmd.insert)
        begin
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            mem_wdata = id_reg;
        end
    end

    always_comb
    begin
        mem_re    = cmd.rd_head || cmd.srch_rd || cmd.sh_rd;
        mem_raddr = addr_reg;
        if (cmd.rd_head)
        begin
            mem_raddr = head_reg;
        end
        else if (cmd.sh_rd)
        begin
            mem_raddr = addr_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        if (cfg_we)
        begin
            head_next = '0;
            cnt_next  = cnt_cfg;
            k_next    = '0;
        end
        else if (cmd.fill_step)
        begin
            k_next = k_reg + AW'(1);
        end
        else if (cmd.load_item)
        begin
            k_next    = '0;
            addr_next = head_reg;
        end
        else if (cmd.serve_commit)
        begin
            head_next = wrap_inc(head_reg);
        end
        else if (cmd.srch_next)
        begin
            k_next    = k_reg + AW'(1);
            addr_next = wrap_inc(addr_reg);
        end
        else if (cmd.sh_wr)
        begin
            k_next    = k_reg - AW'(1);
            addr_next = addr_dec;
        end
        else if (cmd.insert)
        begin
            head_next = head_dec;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= CNT_W'(POP_INIT);
            k_reg         <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            id_reg <= in_item.person_id[SLOT_W-1:0];
        end
        if (cmd.serve_commit)
        begin
            res_served_reg <= ID_W'(rdata_reg);
            res_status_reg <= STAT_SERVED;
        end
        else if (cmd.put_head || cmd.insert)
        begin
            res_served_reg <= '0;
            res_status_reg <= STAT_EXPEDITED;
        end
        else if (cmd.drop)
        begin
            res_served_reg <= '0;
            res_status_reg <= STAT_DROPPED;
        end
        if (cmd.out_load)
        begin
            out_item_reg.served_id <= res_served_reg;
            out_item_reg.status    <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for move_to_front_rotating_queue: directed table, then random phases.
module testbench;
    import mtfq_pkg::*;

    localparam int     CAPACITY     = 1024;
    localparam int     RANDOM_ITEMS = 550;
    localparam int     SETTLE       = 16;
    localparam int     IDLE_PCT     = 13;
    localparam longint CYCLE_LIMIT  = 10_000_000;

    typedef enum logic {ROW_ITEM, ROW_POP} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                cmd;
        logic [ID_W-1:0]     value;
        logic                fixed;
        logic [ID_W-1:0]     exp_id;
        logic [STATUS_W-1:0] exp_status;
    } row_t;

    localparam row_t DIRECTED [0:27] = '{
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1,     STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd2,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd1024,  1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'hFFFF,  1'b1, 16'd0,     STAT_DROPPED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd0,     1'b1, 16'd0,     STAT_DROPPED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1024,  STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'hFFFF,  1'b1, 16'd3,     STAT_SERVED},
        '{ROW_POP,  CMD_SERVE,    16'd0,     1'b0, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1,     STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd1,     1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd0,     1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'hFFFF,  1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'hFFFF,  STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd1,     1'b0, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b0, 16'd0,     STAT_SERVED},
        '{ROW_POP,  CMD_SERVE,    16'd2047,  1'b0, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'h8000,  1'b1, 16'd0,     STAT_DROPPED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd1,     1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'd1,     STAT_SERVED},
        '{ROW_POP,  CMD_SERVE,    16'd1025,  1'b0, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'd1024,  1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_POP,  CMD_SERVE,    16'd1023,  1'b0, 16'd0,     STAT_SERVED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'hAAAA,  1'b1, 16'd0,     STAT_EXPEDITED},
        '{ROW_ITEM, CMD_EXPEDITE, 16'h5555,  1'b1, 16'd0,     STAT_DROPPED},
        '{ROW_ITEM, CMD_SERVE,    16'd0,     1'b1, 16'hAAAA,  STAT_SERVED}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [POP_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;

    logic [ID_W-1:0] lineup[$];
    out_item_t       replies_due[$];
    out_item_t       oldest_reply;
    int              errors = 0;
    bit              calm = 1'b0;
    longint          cycles = 0;

    move_to_front_rotating_queue #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reload_lineup(input logic [POP_W-1:0] pop);
        int count;
        count = (pop == 0) ? 1 : (pop > CAPACITY) ? CAPACITY : int'(pop);
        lineup.delete();
        for (int i = 1; i <= count; i++)
        begin
            lineup.insert(lineup.size(), ID_W'(i));
        end
    endfunction

    function automatic out_item_t apply_command(input in_item_t cmd_item);
        out_item_t       reply;
        logic [ID_W-1:0] head;
        int              pos;
        reply.served_id = '0;
        if (cmd_item.command == CMD_SERVE)
        begin
            head = lineup[0];
            lineup.delete(0);
            lineup.insert(lineup.size(), head);
            reply.served_id = head;
            reply.status    = STAT_SERVED;
        end
        else
        begin
            pos = -1;
            for (int i = 0; i < lineup.size() && pos < 0; i++)
            begin
                if (lineup[i] == cmd_item.person_id)
                    pos = i;
            end
            if (pos >= 0)
            begin
                lineup.delete(pos);
                lineup.insert(0, cmd_item.person_id);
                reply.status = STAT_EXPEDITED;
            end
            else if (lineup.size() < CAPACITY)
            begin
                lineup.insert(0, cmd_item.person_id);
                reply.status = STAT_EXPEDITED;
            end
            else
            begin
                reply.status = STAT_DROPPED;
            end
        end
        return reply;
    endfunction

    task automatic send_command(input in_item_t cmd_item, input bit fixed,
                                input out_item_t typed);
        out_item_t predicted;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= cmd_item;
        do @(posedge clk); while (in_stall);
        predicted = apply_command(cmd_item);
        replies_due.insert(replies_due.size(), fixed ? typed : predicted);
    endtask

    task automatic write_population(input logic [POP_W-1:0] pop);
        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pop;
        @(posedge clk);
        cfg_we <= 1'b0;
        reload_lineup(pop);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual served_id %h status %0d",
                         $time, out_item.served_id, out_item.status);
            end
            else
            begin
                oldest_reply = replies_due[0];
                replies_due.delete(0);
                if (out_item.served_id !== oldest_reply.served_id)
                begin
                    errors++;
                    $display("%0t: served_id expected %h actual %h",
                             $time, oldest_reply.served_id, out_item.served_id);
                end
                if (out_item.status !== oldest_reply.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_reply.status, out_item.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        row_t             row;
        in_item_t         cmd_item;
        out_item_t        typed;
        int               sent;
        int               phase;
        int               count;
        int               pick;
        int               span;
        bit               big;
        logic [POP_W-1:0] pop;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        reload_lineup(POP_W'(POP_RESET));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_POP)
            begin
                write_population(row.value[POP_W-1:0]);
            end
            else
            begin
                cmd_item.command   = row.cmd;
                cmd_item.person_id = row.value;
                typed.served_id    = row.exp_id;
                typed.status       = row.exp_status;
                send_command(cmd_item, row.fixed, typed);
            end
        end

        // random phases, mostly small populations; phase 3 runs without idling
        typed = '0;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            big  = (pick < 8);
            if (big)
            begin
                case ($urandom_range(0, 3))
                    0:       pop = POP_W'(CAPACITY);
                    1:       pop = POP_W'(CAPACITY - 1);
                    2:       pop = '1;
                    default: pop = POP_W'($urandom_range(CAPACITY + 1, 2047));
                endcase
            end
            else if (pick < 14)
            begin
                pop = POP_W'($urandom_range(0, 1));
            end
            else
            begin
                pop = POP_W'($urandom_range(2, 24));
            end
            write_population(pop);
            calm  = (phase == 3);
            count = big ? $urandom_range(4, 10) : $urandom_range(20, 45);
            span  = lineup.size() + 6;
            repeat (count)
            begin
                cmd_item.command = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    cmd_item.person_id = ID_W'($urandom_range(0, span));
                else if (pick < 80)
                    cmd_item.person_id = lineup[$urandom_range(0, lineup.size() - 1)];
                else
                    cmd_item.person_id = ID_W'($urandom());
                send_command(cmd_item, 1'b0, typed);
                sent++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
